/* hdl/gcd_pkg.sv */
// ----------------------------------------------------------------------------
// gcd_pkg
// Shared types, constants and helpers for the great-circle distance core.
// ----------------------------------------------------------------------------
package gcd_pkg;

  localparam int TABLE_LEN = 40;

  // Divisor left after taking 2^10 out of 3.6e9, and the rounding term scaled the same way
  localparam logic [21:0] DIV_K     = 22'd3515625;
  localparam logic [21:0] FULL_RND  = 22'd1757812;
  localparam logic [20:0] HALF_RND  = 21'd1757812;

  // floor(2^54 / DIV_K) and floor(2^53 / DIV_K)
  localparam logic [32:0] RECIP_FULL = 33'd5124095576;
  localparam logic [32:0] RECIP_HALF = 33'd2562047788;

  localparam logic signed [35:0] COORD_TURN  = 36'sd3600000000;
  localparam logic signed [35:0] COORD_TURN2 = 36'sd7200000000;

  localparam logic signed [33:0] GAIN_Q30  = 34'sd652032874;
  localparam logic [30:0]        Q30_ONE   = 31'd1073741824;
  localparam logic [29:0]        RAD_SCALE = 30'd843314857;
  localparam logic [30:0]        OUT_MAX   = 31'h7FFF_FFFF;
  localparam logic [29:0]        R100_RESET = 30'd637100000;

  localparam logic [29:0] ATAN_TURN [TABLE_LEN] = '{
    30'd536870912, 30'd316933406, 30'd167458907, 30'd85004756, 30'd42667331,
    30'd21354465, 30'd10679838, 30'd5340245, 30'd2670163, 30'd1335087,
    30'd667544, 30'd333772, 30'd166886, 30'd83443, 30'd41722,
    30'd20861, 30'd10430, 30'd5215, 30'd2608, 30'd1304,
    30'd652, 30'd326, 30'd163, 30'd81, 30'd41,
    30'd20, 30'd10, 30'd5, 30'd3, 30'd1,
    30'd1, 30'd0, 30'd0, 30'd0, 30'd0,
    30'd0, 30'd0, 30'd0, 30'd0, 30'd0
  };

  typedef struct packed {
    logic signed [33:0] x;
    logic signed [33:0] y;
    logic signed [32:0] z;
    logic [1:0]         q;
  } rot_t;

  typedef struct packed {
    logic [61:0] v;
    logic [32:0] rem;
    logic [30:0] root;
  } sqrt_t;

  typedef struct packed {
    logic signed [33:0] x;
    logic signed [33:0] y;
    logic signed [33:0] z;
  } vec_t;

  // Reduce a coordinate difference into [0, 3.6e9)
  function automatic logic [31:0] coord_mod(input logic signed [33:0] v);
    logic signed [35:0] e;
    logic signed [35:0] t;
    e = 36'(v);
    if (e < -COORD_TURN) begin
      t = e + COORD_TURN2;
    end else if (e < 36'sd0) begin
      t = e + COORD_TURN;
    end else if (e >= COORD_TURN) begin
      t = e - COORD_TURN;
    end else begin
      t = e;
    end
    return t[31:0];
  endfunction

endpackage

/* hdl/gcd_div_cell.sv */
// ----------------------------------------------------------------------------
// gcd_div_cell
// Coordinate to binary angle by reciprocal multiplication, three register stages.
// ----------------------------------------------------------------------------
module gcd_div_cell import gcd_pkg::*; #(
  parameter bit HALF = 1'b0
) (
  input  logic        clk_i,
  input  logic [31:0] m_i,
  output logic [31:0] ang_o
);

  localparam logic [32:0] RECIP = HALF ? RECIP_HALF : RECIP_FULL;
  localparam logic [21:0] RND   = HALF ? 22'(HALF_RND) : FULL_RND;
  localparam int          SH    = HALF ? 21 : 22;

  logic [64:0] prod_d, prod_q;
  logic [31:0] m_q;
  logic [31:0] q0, q0_q;
  logic [23:0] num;
  logic [23:0] r_d, r_q;
  logic [1:0]  corr;
  logic [31:0] ang_d, ang_q;

  always_comb begin
    prod_d = 65'(m_i) * 65'(RECIP);
    // the estimate falls short of the quotient by at most two
    q0     = prod_q[63:32];
    // the remainder is below three divisors, so its low bits suffice
    num    = 24'(m_q << SH) + 24'(RND);
    r_d    = num - 24'(q0[23:0] * 24'(DIV_K));
    corr   = 2'((r_q >= 24'(DIV_K)) ? 1 : 0) + 2'((r_q >= 24'd7031250) ? 1 : 0);
    ang_d  = q0_q + 32'(corr);
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    m_q    <= m_i;
    r_q    <= r_d;
    q0_q   <= q0;
    ang_q  <= ang_d;
  end

  assign ang_o = ang_q;

endmodule

/* hdl/gcd_rot_cell.sv */
// ----------------------------------------------------------------------------
// gcd_rot_cell
// One micro-rotation of the rotation-mode CORDIC for sine and cosine.
// ----------------------------------------------------------------------------
module gcd_rot_cell import gcd_pkg::*; #(
  parameter int STAGE = 0
) (
  input  logic clk_i,
  input  rot_t in_i,
  output rot_t out_o
);

  localparam logic signed [32:0] AT = signed'({3'b000, ATAN_TURN[STAGE]});

  logic signed [33:0] dx, dy;
  rot_t out_d, out_q;

  always_comb begin
    dx = in_i.y >>> STAGE;
    dy = in_i.x >>> STAGE;
    out_d.q = in_i.q;
    if (!in_i.z[32]) begin
      out_d.x = in_i.x - dx;
      out_d.y = in_i.y + dy;
      out_d.z = in_i.z - AT;
    end else begin
      out_d.x = in_i.x + dx;
      out_d.y = in_i.y - dy;
      out_d.z = in_i.z + AT;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_o = out_q;

endmodule

/* hdl/gcd_sqrt_cell.sv */
// ----------------------------------------------------------------------------
// gcd_sqrt_cell
// One result bit of the digit-by-digit integer square root.
// ----------------------------------------------------------------------------
module gcd_sqrt_cell import gcd_pkg::*; (
  input  logic  clk_i,
  input  sqrt_t in_i,
  output sqrt_t out_o
);

  logic [34:0] rem2, trial;
  logic        ge;
  sqrt_t       out_d, out_q;

  always_comb begin
    rem2  = {in_i.rem, in_i.v[61:60]};
    trial = {2'b00, in_i.root, 2'b01};
    ge    = (rem2 >= trial);
    out_d.rem  = ge ? 33'(rem2 - trial) : rem2[32:0];
    out_d.root = {in_i.root[29:0], ge};
    out_d.v    = {in_i.v[59:0], 2'b00};
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_o = out_q;

endmodule

/* hdl/gcd_vec_cell.sv */
// ----------------------------------------------------------------------------
// gcd_vec_cell
// One micro-rotation of the vectoring-mode CORDIC for the arctangent.
// ----------------------------------------------------------------------------
module gcd_vec_cell import gcd_pkg::*; #(
  parameter int STAGE = 0
) (
  input  logic clk_i,
  input  vec_t in_i,
  output vec_t out_o
);

  localparam logic signed [33:0] AT = signed'({4'b0000, ATAN_TURN[STAGE]});

  logic signed [33:0] dx, dy;
  vec_t out_d, out_q;

  always_comb begin
    dx = in_i.y >>> STAGE;
    dy = in_i.x >>> STAGE;
    // drive y towards zero
    if (!in_i.y[33]) begin
      out_d.x = in_i.x + dx;
      out_d.y = in_i.y - dy;
      out_d.z = in_i.z + AT;
    end else begin
      out_d.x = in_i.x - dx;
      out_d.y = in_i.y + dy;
      out_d.z = in_i.z - AT;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_o = out_q;

endmodule

/* hdl/great_circle_distance_core.sv */
// ----------------------------------------------------------------------------
// great_circle_distance_core
// Haversine distance between two positions, fully pipelined fixed point.
// ----------------------------------------------------------------------------
// Usage:
//   Drive the four coordinates and pulse start; busy stays low, so a request
//   is taken on every cycle that start is high.
//   Each request gives one distance on distance_cm_o, marked by valid_o for
//   exactly one cycle. Throughput is one request per cycle; the pipeline is
//   made up of the chains of cells: 3 reciprocal divider stages,
//   CORDIC_STAGES sine/cosine steps, 31 root steps, CORDIC_STAGES arctangent
//   steps, plus 9 registers of glue and products.
//   The radius register is written through cfg_valid_i/cfg_data_i, always
//   ready; write it only while no request is in flight.
//   Reset clears the valid pipeline and sets the radius to 6371000 m; a
//   request in flight at reset is dropped. The receiver cannot stall: each
//   result is shown once and must be taken in that cycle.
// ----------------------------------------------------------------------------
module great_circle_distance_core import gcd_pkg::*; #(
  parameter int CORDIC_STAGES = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic signed [30:0] first_latitude_i,
  input  logic signed [31:0] first_longitude_i,
  input  logic signed [30:0] second_latitude_i,
  input  logic signed [31:0] second_longitude_i,
  output logic               valid_o,
  output logic [30:0]        distance_cm_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [22:0]        cfg_data_i
);

  localparam int N      = CORDIC_STAGES;
  localparam int SQ_N   = 31;
  localparam int SQ_IDX = 38 + N;
  localparam int LAT    = 43 + 2 * N;

  function automatic logic signed [31:0] clamp_q30(input logic signed [33:0] v);
    if (v > 34'sd1073741824) begin
      return 32'sd1073741824;
    end else if (v < -34'sd1073741824) begin
      return -32'sd1073741824;
    end else begin
      return v[31:0];
    end
  endfunction

  logic [LAT-1:0] vld_q;
  logic [29:0]    r100_q;

  assign busy        = 1'b0;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= '0;
      r100_q <= R100_RESET;
    end else begin
      vld_q <= {vld_q[LAT-2:0], start};
      if (cfg_valid_i) begin
        r100_q <= 30'(cfg_data_i) * 30'd100;
      end
    end
  end

  // Input stage: differences and reduction into one turn
  logic signed [33:0] dlat, dlon;
  logic [31:0]        m_q [4];

  assign dlat = 34'(second_latitude_i) - 34'(first_latitude_i);
  assign dlon = 34'(second_longitude_i) - 34'(first_longitude_i);

  always_ff @(posedge clk_i) begin
    m_q[0] <= coord_mod(dlat);
    m_q[1] <= coord_mod(dlon);
    m_q[2] <= coord_mod(34'(first_latitude_i));
    m_q[3] <= coord_mod(34'(second_latitude_i));
  end

  // Angle conversion: lanes 0,1 give half angles, lanes 2,3 full angles
  logic [31:0] ang [4];
  rot_t        rt  [4][N+1];

  for (genvar l = 0; l < 4; l++) begin : g_lane
    gcd_div_cell #(.HALF((l < 2) ? 1'b1 : 1'b0)) u_div (
      .clk_i (clk_i),
      .m_i   (m_q[l]),
      .ang_o (ang[l])
    );

    assign rt[l][0].x = GAIN_Q30;
    assign rt[l][0].y = '0;
    assign rt[l][0].z = signed'({3'b000, ang[l][29:0]});
    assign rt[l][0].q = ang[l][31:30];

    for (genvar k = 0; k < N; k++) begin : g_rot
      gcd_rot_cell #(.STAGE(k)) u_rot (
        .clk_i (clk_i),
        .in_i  (rt[l][k]),
        .out_o (rt[l][k+1])
      );
    end
  end

  // Clamp and unfold the quadrant
  logic signed [31:0] cs_c_q [4];
  logic signed [31:0] cs_s_q [4];

  for (genvar l = 0; l < 4; l++) begin : g_map
    logic signed [31:0] cx, sy;
    assign cx = clamp_q30(rt[l][N].x);
    assign sy = clamp_q30(rt[l][N].y);

    always_ff @(posedge clk_i) begin
      case (rt[l][N].q)
        2'd0: begin cs_c_q[l] <= cx;  cs_s_q[l] <= sy;  end
        2'd1: begin cs_c_q[l] <= -sy; cs_s_q[l] <= cx;  end
        2'd2: begin cs_c_q[l] <= -cx; cs_s_q[l] <= -sy; end
        default: begin cs_c_q[l] <= sy; cs_s_q[l] <= -cx; end
      endcase
    end
  end

  // Haversine term a
  logic signed [63:0] p_sa, p_sb, p_cc, p_t;
  logic signed [31:0] sa2_q, sb2_q, cc_q, sa2_d_q, t_q;
  logic signed [32:0] a_sum;
  logic [30:0]        a_q;

  assign p_sa = cs_s_q[0] * cs_s_q[0];
  assign p_sb = cs_s_q[1] * cs_s_q[1];
  assign p_cc = cs_c_q[2] * cs_c_q[3];
  assign p_t  = cc_q * sb2_q;
  assign a_sum = 33'(sa2_d_q) + 33'(t_q);

  always_ff @(posedge clk_i) begin
    sa2_q   <= 32'(p_sa >>> 30);
    sb2_q   <= 32'(p_sb >>> 30);
    cc_q    <= 32'(p_cc >>> 30);
    sa2_d_q <= sa2_q;
    t_q     <= 32'(p_t >>> 30);
    if (a_sum[32]) begin
      a_q <= '0;
    end else if (a_sum > 33'sd1073741824) begin
      a_q <= Q30_ONE;
    end else begin
      a_q <= a_sum[30:0];
    end
  end

  // Square roots of a and 1-a
  sqrt_t       sq [2][SQ_N+1];
  logic [30:0] b_val;

  assign b_val = 31'(Q30_ONE - a_q);

  assign sq[0][0].v    = {1'b0, a_q, 30'd0};
  assign sq[0][0].rem  = '0;
  assign sq[0][0].root = '0;
  assign sq[1][0].v    = {1'b0, b_val, 30'd0};
  assign sq[1][0].rem  = '0;
  assign sq[1][0].root = '0;

  for (genvar l = 0; l < 2; l++) begin : g_sq_lane
    for (genvar k = 0; k < SQ_N; k++) begin : g_sq
      gcd_sqrt_cell u_sqrt (
        .clk_i (clk_i),
        .in_i  (sq[l][k]),
        .out_o (sq[l][k+1])
      );
    end
  end

  // Arctangent of the two roots
  vec_t vc [N+1];

  assign vc[0].x = signed'({3'b000, sq[1][SQ_N].root});
  assign vc[0].y = signed'({3'b000, sq[0][SQ_N].root});
  assign vc[0].z = '0;

  for (genvar k = 0; k < N; k++) begin : g_vec
    gcd_vec_cell #(.STAGE(k)) u_vec (
      .clk_i (clk_i),
      .in_i  (vc[k]),
      .out_o (vc[k+1])
    );
  end

  // Scale to radians, then to centimetres
  logic [30:0] zc;
  logic [60:0] prod1_q;
  logic [31:0] ang_q;
  logic [61:0] prod2_q;
  logic [62:0] rnd2;
  logic [30:0] dist_q;

  always_comb begin
    if (vc[N].z[33]) begin
      zc = '0;
    end else if (vc[N].z > 34'sd1073741824) begin
      zc = Q30_ONE;
    end else begin
      zc = vc[N].z[30:0];
    end
  end

  assign rnd2 = 63'(prod2_q) + (63'd1 << 29);

  always_ff @(posedge clk_i) begin
    prod1_q <= 61'(zc) * 61'(RAD_SCALE);
    ang_q   <= 32'((prod1_q + (61'd1 << 27)) >> 28);
    prod2_q <= 62'(ang_q) * 62'(r100_q);
    // saturate above the output range
    if (rnd2[62:30] > 33'(OUT_MAX)) begin
      dist_q <= OUT_MAX;
    end else begin
      dist_q <= rnd2[60:30];
    end
  end

  assign valid_o       = vld_q[LAT-1];
  assign distance_cm_o = dist_q;

`ifndef SYNTH
  a_result_follows_request: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> $past(start, LAT)
  ) else $error("result without a matching request");

  a_roots_bound: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    vld_q[SQ_IDX] |->
      (62'(sq[0][SQ_N].root) * 62'(sq[0][SQ_N].root)
       + 62'(sq[1][SQ_N].root) * 62'(sq[1][SQ_N].root) <= (62'd1 << 60))
  ) else $error("root squares exceed one");

  a_roots_low: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    vld_q[SQ_IDX] |->
      (62'(sq[0][SQ_N].root) * 62'(sq[0][SQ_N].root)
       + 62'(sq[1][SQ_N].root) * 62'(sq[1][SQ_N].root) > ((62'd1 << 60) - (62'd1 << 33)))
  ) else $error("root squares fall short of one");
`endif

endmodule
